>>> rtl/ahkr_pkg.sv
// shared types, constants and codes for the joystick axis hysteresis and key repeat block
`default_nettype none
package ahkr_pkg;

    localparam int AXIS_COUNT = 8;
    localparam int AXIS_W     = 3;
    localparam int THR_W      = 12;
    localparam int MS_W       = 16;
    localparam int TIME_W     = 32;
    localparam int DIR_W      = 2;
    localparam int OP_W       = 2;
    localparam int REG_IDX_W  = 3;
    localparam int PADDR_W    = 5;

    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_CAL     = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;

    localparam logic [DIR_W-1:0] DIR_CENTER = 2'b00;
    localparam logic [DIR_W-1:0] DIR_HIGH   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_LOW    = 2'b11;

    localparam logic [REG_IDX_W-1:0] REG_LO_ENTER = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LO_HOLD  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HI_HOLD  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HI_ENTER = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DELAY    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 3'd5;

    localparam logic [THR_W-1:0] RST_LO_ENTER = 12'd1000;
    localparam logic [THR_W-1:0] RST_LO_HOLD  = 12'd1400;
    localparam logic [THR_W-1:0] RST_HI_HOLD  = 12'd2700;
    localparam logic [THR_W-1:0] RST_HI_ENTER = 12'd3100;
    localparam logic [MS_W-1:0]  RST_DELAY    = 16'd350;
    localparam logic [MS_W-1:0]  RST_INTERVAL = 16'd90;

    localparam logic [THR_W-1:0] CAL_FAR  = 12'd700;
    localparam logic [THR_W-1:0] CAL_NEAR = 12'd350;
    localparam logic [THR_W-1:0] ADC_MAX  = 12'd4095;

    typedef struct packed {
        logic [THR_W-1:0] lo_enter;
        logic [THR_W-1:0] lo_hold;
        logic [THR_W-1:0] hi_hold;
        logic [THR_W-1:0] hi_enter;
        logic [MS_W-1:0]  delay;
        logic [MS_W-1:0]  interval;
    } cfg_t;

    typedef struct packed {
        logic [THR_W-1:0]  lo_enter;
        logic [THR_W-1:0]  lo_hold;
        logic [THR_W-1:0]  hi_hold;
        logic [THR_W-1:0]  hi_enter;
        logic [DIR_W-1:0]  dir;
        logic [TIME_W-1:0] deadline;
    } axis_entry_t;

    typedef struct packed {
        logic             emit;
        logic [DIR_W-1:0] dir;
    } result_t;

    localparam axis_entry_t RESET_ENTRY = '{
        lo_enter: RST_LO_ENTER,
        lo_hold:  RST_LO_HOLD,
        hi_hold:  RST_HI_HOLD,
        hi_enter: RST_HI_ENTER,
        dir:      DIR_CENTER,
        deadline: '0
    };

endpackage
`default_nettype wire

>>> rtl/ahkr_cfg_regs.sv
// apb configuration registers: default thresholds and repeat timing
`default_nettype none
module ahkr_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ahkr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output ahkr_pkg::cfg_t                    cfg
);

    ahkr_pkg::cfg_t                   cfg_reg;
    logic                             wr_en;
    logic [ahkr_pkg::REG_IDX_W-1:0]   idx;

    assign pready = 1'b1;
    assign idx    = paddr[ahkr_pkg::PADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lo_enter <= ahkr_pkg::RST_LO_ENTER;
            cfg_reg.lo_hold  <= ahkr_pkg::RST_LO_HOLD;
            cfg_reg.hi_hold  <= ahkr_pkg::RST_HI_HOLD;
            cfg_reg.hi_enter <= ahkr_pkg::RST_HI_ENTER;
            cfg_reg.delay    <= ahkr_pkg::RST_DELAY;
            cfg_reg.interval <= ahkr_pkg::RST_INTERVAL;
        end else if (wr_en) begin
            case (idx)
                ahkr_pkg::REG_LO_ENTER: cfg_reg.lo_enter <= pwdata[ahkr_pkg::THR_W-1:0];
                ahkr_pkg::REG_LO_HOLD:  cfg_reg.lo_hold  <= pwdata[ahkr_pkg::THR_W-1:0];
                ahkr_pkg::REG_HI_HOLD:  cfg_reg.hi_hold  <= pwdata[ahkr_pkg::THR_W-1:0];
                ahkr_pkg::REG_HI_ENTER: cfg_reg.hi_enter <= pwdata[ahkr_pkg::THR_W-1:0];
                ahkr_pkg::REG_DELAY:    cfg_reg.delay    <= pwdata[ahkr_pkg::MS_W-1:0];
                ahkr_pkg::REG_INTERVAL: cfg_reg.interval <= pwdata[ahkr_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ahkr_pkg::REG_LO_ENTER: prdata = 32'(cfg_reg.lo_enter);
            ahkr_pkg::REG_LO_HOLD:  prdata = 32'(cfg_reg.lo_hold);
            ahkr_pkg::REG_HI_HOLD:  prdata = 32'(cfg_reg.hi_hold);
            ahkr_pkg::REG_HI_ENTER: prdata = 32'(cfg_reg.hi_enter);
            ahkr_pkg::REG_DELAY:    prdata = 32'(cfg_reg.delay);
            ahkr_pkg::REG_INTERVAL: prdata = 32'(cfg_reg.interval);
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/ahkr_axis_mem.sv
// per-axis state memory with registered read and per-entry valid bits
`default_nettype none
module ahkr_axis_mem (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        rd_en,
    input  wire logic [ahkr_pkg::AXIS_W-1:0] rd_addr,
    output ahkr_pkg::axis_entry_t            rd_data,
    input  wire logic                        wr_en,
    input  wire logic [ahkr_pkg::AXIS_W-1:0] wr_addr,
    input  wire ahkr_pkg::axis_entry_t       wr_data
);

    ahkr_pkg::axis_entry_t                 mem [ahkr_pkg::AXIS_COUNT];
    logic [ahkr_pkg::AXIS_COUNT-1:0]       valid_reg;
    ahkr_pkg::axis_entry_t                 rd_data_reg;
    logic                                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never written since reset reads as the reset defaults
    assign rd_data = rd_valid_reg ? rd_data_reg : ahkr_pkg::RESET_ENTRY;

endmodule
`default_nettype wire

>>> rtl/ahkr_axis_update.sv
// next axis state and event for one item: hysteresis, repeat timing, calibration
`default_nettype none
module ahkr_axis_update (
    input  wire logic [ahkr_pkg::OP_W-1:0]   op,
    input  wire logic                        axis_ok,
    input  wire logic [ahkr_pkg::THR_W-1:0]  raw,
    input  wire logic [ahkr_pkg::TIME_W-1:0] now_ms,
    input  wire ahkr_pkg::axis_entry_t       cur,
    input  wire ahkr_pkg::cfg_t              cfg,
    output ahkr_pkg::axis_entry_t            nxt,
    output logic                             wr_en,
    output ahkr_pkg::result_t                res
);

    logic [ahkr_pkg::DIR_W-1:0]  d;
    logic [ahkr_pkg::TIME_W-1:0] diff;
    logic [ahkr_pkg::THR_W:0]    sum_near;
    logic [ahkr_pkg::THR_W:0]    sum_far;

    always_comb begin
        if (cur.dir == ahkr_pkg::DIR_LOW && raw <= cur.lo_hold) begin
            d = ahkr_pkg::DIR_LOW;
        end else if (cur.dir == ahkr_pkg::DIR_HIGH && raw >= cur.hi_hold) begin
            d = ahkr_pkg::DIR_HIGH;
        end else if (raw <= cur.lo_enter) begin
            d = ahkr_pkg::DIR_LOW;
        end else if (raw >= cur.hi_enter) begin
            d = ahkr_pkg::DIR_HIGH;
        end else begin
            d = ahkr_pkg::DIR_CENTER;
        end
    end

    assign diff     = now_ms - cur.deadline;
    assign sum_near = {1'b0, raw} + {1'b0, ahkr_pkg::CAL_NEAR};
    assign sum_far  = {1'b0, raw} + {1'b0, ahkr_pkg::CAL_FAR};

    always_comb begin
        nxt       = cur;
        wr_en     = 1'b0;
        res.emit  = 1'b0;
        res.dir   = ahkr_pkg::DIR_CENTER;
        if (axis_ok && op == ahkr_pkg::OP_CAL) begin
            wr_en        = 1'b1;
            nxt.lo_enter = (raw >= ahkr_pkg::CAL_FAR) ? raw - ahkr_pkg::CAL_FAR : '0;
            nxt.lo_hold  = (raw >= ahkr_pkg::CAL_NEAR) ? raw - ahkr_pkg::CAL_NEAR : '0;
            nxt.hi_hold  = (sum_near > {1'b0, ahkr_pkg::ADC_MAX}) ?
                           ahkr_pkg::ADC_MAX : sum_near[ahkr_pkg::THR_W-1:0];
            nxt.hi_enter = (sum_far > {1'b0, ahkr_pkg::ADC_MAX}) ?
                           ahkr_pkg::ADC_MAX : sum_far[ahkr_pkg::THR_W-1:0];
            nxt.dir      = ahkr_pkg::DIR_CENTER;
            nxt.deadline = '0;
        end else if (axis_ok && op == ahkr_pkg::OP_SAMPLE) begin
            res.dir = d;
            if (d != cur.dir) begin
                wr_en        = 1'b1;
                nxt.dir      = d;
                nxt.deadline = (d == ahkr_pkg::DIR_CENTER) ? '0 :
                               now_ms + ahkr_pkg::TIME_W'(cfg.delay);
                res.emit     = (d != ahkr_pkg::DIR_CENTER);
            end else if (d != ahkr_pkg::DIR_CENTER && !diff[ahkr_pkg::TIME_W-1]) begin
                // deadline reached, wrap-safe
                wr_en        = 1'b1;
                nxt.deadline = now_ms + ahkr_pkg::TIME_W'(cfg.interval);
                res.emit     = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/axis_hysteresis_key_repeat_top.sv
// top level: item sequencer around the axis state memory
// Joystick axis hysteresis with key auto-repeat.
// Input channel s_*: one item per converter sample or calibration command;
// s_tuser carries the op, s_tdata axis, raw reading and millisecond time.
// Result channel m_*: exactly one item per input item; m_tuser is the emit
// flag, m_tdata the axis and the direction after a sample, else centre.
// Per-axis thresholds, direction and repeat deadline live in an 8-entry
// memory with a registered read. A sample or calibrate item is read at
// acceptance, then updated and written back in the execute state once the
// output register is free, where its result is registered. No new item is
// taken until the last leaves execution. Restore-defaults sweeps all 8
// entries, one per cycle. Only one item is in flight, so no access overlaps.
// Reset loads the default registers with their reset values and marks all
// entries as reading the reset thresholds, centred, deadline zero.
// A finished result waits in the output register while a stalled receiver
// holds it; the next item may be accepted and read meanwhile, and its
// write-back waits until the output register is free. The user writes
// configuration through the apb port only while idle; it is not enforced.
`default_nettype none
module axis_hysteresis_key_repeat_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // s_tdata: axis[2:0], raw[14:3], now_ms[46:15], zero[47]
    input  wire logic [47:0]                  s_tdata,
    // s_tuser: op[1:0]
    input  wire logic [1:0]                   s_tuser,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // m_tdata: event_axis[2:0], event_direction[4:3], zero[7:5]
    output logic      [7:0]                   m_tdata,
    // m_tuser: emit[0]
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ahkr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [ahkr_pkg::AXIS_W-1:0]   cnt_reg, cnt_next;
    logic [ahkr_pkg::OP_W-1:0]     op_reg;
    logic [ahkr_pkg::AXIS_W-1:0]   axis_reg;
    logic [ahkr_pkg::THR_W-1:0]    raw_reg;
    logic [ahkr_pkg::TIME_W-1:0]   now_reg;
    logic                          m_valid_reg, m_valid_next;
    logic                          emit_reg;
    logic [ahkr_pkg::AXIS_W-1:0]   ev_axis_reg;
    logic [ahkr_pkg::DIR_W-1:0]    ev_dir_reg;

    ahkr_pkg::cfg_t                cfg;
    ahkr_pkg::axis_entry_t         cur, nxt, dflt, wr_data;
    ahkr_pkg::result_t             res;
    logic                          upd_wr;
    logic                          axis_ok;
    logic                          s_accept;
    logic                          out_free;
    logic                          load_out;
    logic                          mem_wr;
    logic [ahkr_pkg::AXIS_W-1:0]   mem_wr_addr;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == ST_EXEC) && out_free;
    assign axis_ok  = ({1'b0, axis_reg} < (ahkr_pkg::AXIS_W+1)'(ahkr_pkg::AXIS_COUNT));

    ahkr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ahkr_axis_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (s_tdata[ahkr_pkg::AXIS_W-1:0]),
        .rd_data (cur),
        .wr_en   (mem_wr),
        .wr_addr (mem_wr_addr),
        .wr_data (wr_data)
    );

    ahkr_axis_update u_upd (
        .op      (op_reg),
        .axis_ok (axis_ok),
        .raw     (raw_reg),
        .now_ms  (now_reg),
        .cur     (cur),
        .cfg     (cfg),
        .nxt     (nxt),
        .wr_en   (upd_wr),
        .res     (res)
    );

    always_comb begin
        dflt.lo_enter = cfg.lo_enter;
        dflt.lo_hold  = cfg.lo_hold;
        dflt.hi_hold  = cfg.hi_hold;
        dflt.hi_enter = cfg.hi_enter;
        dflt.dir      = ahkr_pkg::DIR_CENTER;
        dflt.deadline = '0;
    end

    always_comb begin
        if (state_reg == ST_SWEEP) begin
            mem_wr      = 1'b1;
            mem_wr_addr = cnt_reg;
            wr_data     = dflt;
        end else begin
            mem_wr      = load_out && upd_wr;
            mem_wr_addr = axis_reg;
            wr_data     = nxt;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    cnt_next     = '0;
                    state_next   = (op_reg == ahkr_pkg::OP_RESTORE) ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP: begin
                cnt_next = cnt_reg + ahkr_pkg::AXIS_W'(1);
                if (cnt_reg == ahkr_pkg::AXIS_W'(ahkr_pkg::AXIS_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= s_tuser;
            axis_reg <= s_tdata[2:0];
            raw_reg  <= s_tdata[14:3];
            now_reg  <= s_tdata[46:15];
        end
        if (load_out) begin
            emit_reg    <= res.emit;
            ev_axis_reg <= axis_reg;
            ev_dir_reg  <= res.dir;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = emit_reg;
    assign m_tdata  = {3'b000, ev_dir_reg, ev_axis_reg};

`ifndef ASSERT_OFF
    // a memory write never coincides with the read of a newly accepted item
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_accept && mem_wr))
        else $error("memory write overlaps item read");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_EXEC)
        else $error("accepted item did not enter execution");

    a_sweep_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SWEEP |=> state_reg == ST_SWEEP || state_reg == ST_IDLE)
        else $error("restore sweep left to wrong state");

    a_emit_has_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && emit_reg |-> ev_dir_reg != ahkr_pkg::DIR_CENTER)
        else $error("event emitted with centred direction");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg)
        else $error("result not presented after execution");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
// testbench for the joystick axis hysteresis and key repeat block: directed table, then random
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam logic [ahkr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 225;

    typedef struct packed {
        logic                        emit;
        logic [ahkr_pkg::AXIS_W-1:0] axis;
        logic [ahkr_pkg::DIR_W-1:0]  dir;
    } joy_event_t;

    typedef struct packed {
        logic [ahkr_pkg::OP_W-1:0]   op;
        logic [ahkr_pkg::AXIS_W-1:0] axis;
        logic [ahkr_pkg::THR_W-1:0]  raw;
        logic [ahkr_pkg::TIME_W-1:0] now;
        logic                        typed;
        joy_event_t                  result;
    } stim_row_t;

    localparam joy_event_t NO_CHECK = '0;
    localparam int DIRECTED_ROWS = 24;

    // typed results only where they follow directly from reset values or the op
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ahkr_pkg::OP_SAMPLE,  3'd0, 12'd0,    32'd0,         1'b1,
          '{1'b1, 3'd0, ahkr_pkg::DIR_LOW}},
        '{ahkr_pkg::OP_SAMPLE,  3'd0, 12'd0,    32'd100,       1'b0, NO_CHECK},
        '{ahkr_pkg::OP_SAMPLE,  3'd0, 12'd1400, 32'd350,       1'b0, NO_CHECK},
        '{ahkr_pkg::OP_SAMPLE,  3'd0, 12'd1401, 32'd400,       1'b0, NO_CHECK},
        '{ahkr_pkg::OP_SAMPLE,  3'd1, 12'd4095, 32'd1000,      1'b1,
          '{1'b1, 3'd1, ahkr_pkg::DIR_HIGH}},
        '{ahkr_pkg::OP_SAMPLE,  3'd1, 12'd2700, 32'd1349,      1'b0, NO_CHECK},
        '{ahkr_pkg::OP_SAMPLE,  3'd1, 12'd2700, 32'd1350,      1'b0, NO_CHECK},
        '{ahkr_pkg::OP_SAMPLE,  3'd1, 12'd2699, 32'd1400,      1'b0, NO_CHECK},
        '{OP_UNUSED,            3'd7, 12'd4095, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 3'd7, ahkr_pkg::DIR_CENTER}},
        '{ahkr_pkg::OP_CAL,     3'd2, 12'd0,    32'd0,         1'b1,
          '{1'b0, 3'd2, ahkr_pkg::DIR_CENTER}},
        '{ahkr_pkg::OP_SAMPLE,  3'd2, 12'd0,    32'd10,        1'b0, NO_CHECK},
        '{ahkr_pkg::OP_CAL,     3'd3, 12'd4095, 32'd20,        1'b1,
          '{1'b0, 3'd3, ahkr_pkg::DIR_CENTER}},
        '{ahkr_pkg::OP_SAMPLE,  3'd3, 12'd4095, 32'd30,        1'b0, NO_CHECK},
        '{ahkr_pkg::OP_CAL,     3'd4, 12'd2048, 32'd40,        1'b1,
          '{1'b0, 3'd4, ahkr_pkg::DIR_CENTER}},
        '{ahkr_pkg::OP_SAMPLE,  3'd4, 12'd1348, 32'd50,        1'b0, NO_CHECK},
        // deadline wraps past zero
        '{ahkr_pkg::OP_SAMPLE,  3'd5, 12'd0,    32'hFFFF_FF00, 1'b0, NO_CHECK},
        '{ahkr_pkg::OP_SAMPLE,  3'd5, 12'd0,    32'h0000_0010, 1'b0, NO_CHECK},
        '{ahkr_pkg::OP_SAMPLE,  3'd5, 12'd0,    32'h0000_005E, 1'b0, NO_CHECK},
        '{ahkr_pkg::OP_SAMPLE,  3'd7, 12'd1000, 32'd5,         1'b1,
          '{1'b1, 3'd7, ahkr_pkg::DIR_LOW}},
        '{ahkr_pkg::OP_SAMPLE,  3'd7, 12'd3100, 32'd6,         1'b0, NO_CHECK},
        '{ahkr_pkg::OP_RESTORE, 3'd6, 12'd0,    32'd0,         1'b1,
          '{1'b0, 3'd6, ahkr_pkg::DIR_CENTER}},
        '{ahkr_pkg::OP_SAMPLE,  3'd2, 12'd0,    32'd100,       1'b0, NO_CHECK},
        '{ahkr_pkg::OP_SAMPLE,  3'd6, 12'd2048, 32'd110,       1'b1,
          '{1'b0, 3'd6, ahkr_pkg::DIR_CENTER}},
        '{ahkr_pkg::OP_SAMPLE,  3'd3, 12'd4095, 32'd120,       1'b0, NO_CHECK}
    };

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic [47:0]                   s_tdata;
    logic [1:0]                    s_tuser;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    m_tdata;
    logic                          m_tuser;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ahkr_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // marks the item on the bus as carrying a typed result
    logic                          row_typed;
    joy_event_t                    row_result;

    // predictor state
    ahkr_pkg::cfg_t                dflt;
    logic [ahkr_pkg::THR_W-1:0]    thr_lo_enter [ahkr_pkg::AXIS_COUNT];
    logic [ahkr_pkg::THR_W-1:0]    thr_lo_hold [ahkr_pkg::AXIS_COUNT];
    logic [ahkr_pkg::THR_W-1:0]    thr_hi_hold [ahkr_pkg::AXIS_COUNT];
    logic [ahkr_pkg::THR_W-1:0]    thr_hi_enter [ahkr_pkg::AXIS_COUNT];
    logic [ahkr_pkg::DIR_W-1:0]    axis_dir [ahkr_pkg::AXIS_COUNT];
    logic [ahkr_pkg::TIME_W-1:0]   axis_due [ahkr_pkg::AXIS_COUNT];

    joy_event_t                    pending_events [$];
    int                            items_sent = 0;
    int                            results_seen = 0;
    int                            emits_seen = 0;
    int                            errs = 0;
    int                            cycles = 0;
    int                            ready_left = 0;
    int                            settings_used = 1;
    bit                            calm = 1'b0;
    logic [ahkr_pkg::TIME_W-1:0]   now_clock = '0;

    axis_hysteresis_key_repeat_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void load_defaults();
        for (int i = 0; i < ahkr_pkg::AXIS_COUNT; i++) begin
            thr_lo_enter[i] = dflt.lo_enter;
            thr_lo_hold[i]  = dflt.lo_hold;
            thr_hi_hold[i]  = dflt.hi_hold;
            thr_hi_enter[i] = dflt.hi_enter;
            axis_dir[i]     = ahkr_pkg::DIR_CENTER;
            axis_due[i]     = '0;
        end
    endfunction

    function automatic joy_event_t joystick_step(input logic [ahkr_pkg::OP_W-1:0] op,
                                                 input logic [ahkr_pkg::AXIS_W-1:0] ax,
                                                 input logic [ahkr_pkg::THR_W-1:0] raw,
                                                 input logic [ahkr_pkg::TIME_W-1:0] now);
        joy_event_t ev;
        logic [ahkr_pkg::DIR_W-1:0] d;
        logic [ahkr_pkg::TIME_W-1:0] lag;
        int r;
        int far_c;
        int near_c;
        int top_c;
        ev = '{emit: 1'b0, axis: ax, dir: ahkr_pkg::DIR_CENTER};
        r = int'(raw);
        far_c = int'(ahkr_pkg::CAL_FAR);
        near_c = int'(ahkr_pkg::CAL_NEAR);
        top_c = int'(ahkr_pkg::ADC_MAX);
        case (op)
            ahkr_pkg::OP_RESTORE: begin
                load_defaults();
            end
            ahkr_pkg::OP_CAL: begin
                thr_lo_enter[ax] = ahkr_pkg::THR_W'(r >= far_c ? r - far_c : 0);
                thr_lo_hold[ax]  = ahkr_pkg::THR_W'(r >= near_c ? r - near_c : 0);
                thr_hi_hold[ax]  = ahkr_pkg::THR_W'(r + near_c > top_c ? top_c : r + near_c);
                thr_hi_enter[ax] = ahkr_pkg::THR_W'(r + far_c > top_c ? top_c : r + far_c);
                axis_dir[ax] = ahkr_pkg::DIR_CENTER;
                axis_due[ax] = '0;
            end
            ahkr_pkg::OP_SAMPLE: begin
                // a held direction wins over the press thresholds
                if (axis_dir[ax] == ahkr_pkg::DIR_LOW && raw <= thr_lo_hold[ax])
                    d = ahkr_pkg::DIR_LOW;
                else if (axis_dir[ax] == ahkr_pkg::DIR_HIGH && raw >= thr_hi_hold[ax])
                    d = ahkr_pkg::DIR_HIGH;
                else if (raw <= thr_lo_enter[ax])
                    d = ahkr_pkg::DIR_LOW;
                else if (raw >= thr_hi_enter[ax])
                    d = ahkr_pkg::DIR_HIGH;
                else
                    d = ahkr_pkg::DIR_CENTER;
                lag = now - axis_due[ax];
                if (d != axis_dir[ax]) begin
                    axis_dir[ax] = d;
                    axis_due[ax] = (d == ahkr_pkg::DIR_CENTER) ? '0 :
                                   now + ahkr_pkg::TIME_W'(dflt.delay);
                    ev.emit = (d != ahkr_pkg::DIR_CENTER);
                end else if (d != ahkr_pkg::DIR_CENTER && !lag[ahkr_pkg::TIME_W-1]) begin
                    axis_due[ax] = now + ahkr_pkg::TIME_W'(dflt.interval);
                    ev.emit = 1'b1;
                end
                ev.dir = d;
            end
            default: begin
            end
        endcase
        return ev;
    endfunction

    // receiver: stalls in bursts, none once calm
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            ready_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
            ready_left <= $urandom_range(0, 11);
        end
    end

    always @(posedge aclk) begin : event_check
        joy_event_t want;
        joy_event_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = joystick_step(s_tuser, s_tdata[2:0], s_tdata[14:3], s_tdata[46:15]);
                if (row_typed)
                    want = row_result;
                pending_events.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = '{emit: m_tuser, axis: m_tdata[2:0], dir: m_tdata[4:3]};
                if (got.emit)
                    emits_seen++;
                if (pending_events.size() == 0) begin
                    $error("result with no item outstanding: emit %0d axis %0d dir %0d",
                           got.emit, got.axis, got.dir);
                    errs++;
                end else begin
                    want = pending_events.pop_front();
                    if (got.emit != want.emit) begin
                        $error("emit: expected %0d, got %0d", want.emit, got.emit);
                        errs++;
                    end
                    if (got.axis != want.axis) begin
                        $error("event_axis: expected %0d, got %0d", want.axis, got.axis);
                        errs++;
                    end
                    if (got.dir != want.dir) begin
                        $error("event_direction: expected %b, got %b", want.dir, got.dir);
                        errs++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic [ahkr_pkg::OP_W-1:0] op,
                             input logic [ahkr_pkg::AXIS_W-1:0] ax,
                             input logic [ahkr_pkg::THR_W-1:0] raw,
                             input logic [ahkr_pkg::TIME_W-1:0] now,
                             input logic typed, input joy_event_t result);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= op;
        s_tdata    <= {1'b0, now, raw, ax};
        row_typed  <= typed;
        row_result <= result;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_seen < items_sent);
    endtask

    task automatic apb_write(input logic [ahkr_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ahkr_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // junk puts random bits above each register's width
    task automatic write_config(input ahkr_pkg::cfg_t c, input bit junk);
        logic [31:0] hi;
        hi = junk ? $urandom : '0;
        apb_write(ahkr_pkg::REG_LO_ENTER, {hi[31:ahkr_pkg::THR_W], c.lo_enter});
        apb_write(ahkr_pkg::REG_LO_HOLD,  {hi[31:ahkr_pkg::THR_W], c.lo_hold});
        apb_write(ahkr_pkg::REG_HI_HOLD,  {hi[31:ahkr_pkg::THR_W], c.hi_hold});
        apb_write(ahkr_pkg::REG_HI_ENTER, {hi[31:ahkr_pkg::THR_W], c.hi_enter});
        apb_write(ahkr_pkg::REG_DELAY,    {hi[31:ahkr_pkg::MS_W], c.delay});
        apb_write(ahkr_pkg::REG_INTERVAL, {hi[31:ahkr_pkg::MS_W], c.interval});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dflt = c;
        settings_used++;
    endtask

    function automatic logic [ahkr_pkg::TIME_W-1:0] tick();
        if ($urandom_range(0, 49) == 0)
            now_clock = $urandom;
        else
            now_clock += ahkr_pkg::TIME_W'($urandom_range(0, 120));
        return now_clock;
    endfunction

    // readings near the axis thresholds, the rails, or anywhere
    function automatic logic [ahkr_pkg::THR_W-1:0] pick_level(
            input logic [ahkr_pkg::AXIS_W-1:0] ax);
        int lvl;
        case ($urandom_range(0, 7))
            0: lvl = thr_lo_enter[ax];
            1: lvl = thr_lo_hold[ax];
            2: lvl = thr_hi_hold[ax];
            3: lvl = thr_hi_enter[ax];
            4: lvl = 0;
            5: lvl = int'(ahkr_pkg::ADC_MAX);
            default: lvl = $urandom_range(0, 4095);
        endcase
        lvl += $urandom_range(0, 16) - 8;
        if (lvl < 0)
            lvl = 0;
        if (lvl > int'(ahkr_pkg::ADC_MAX))
            lvl = int'(ahkr_pkg::ADC_MAX);
        return ahkr_pkg::THR_W'(lvl);
    endfunction

    task automatic random_items(input int quota);
        int stop;
        int k;
        int len;
        logic [ahkr_pkg::AXIS_W-1:0] ax;
        logic [ahkr_pkg::THR_W-1:0] lvl;
        stop = items_sent + quota;
        while (items_sent < stop) begin
            k = $urandom_range(0, 99);
            ax = ahkr_pkg::AXIS_W'($urandom);
            if (k < 65) begin
                // a held stick: several samples on one axis around one level
                lvl = pick_level(ax);
                len = $urandom_range(2, 12);
                repeat (len) begin
                    send_item(ahkr_pkg::OP_SAMPLE, ax, pick_level(ax) == lvl ? lvl :
                              lvl ^ ahkr_pkg::THR_W'($urandom_range(0, 3)), tick(),
                              1'b0, NO_CHECK);
                end
            end else if (k < 75) begin
                send_item(ahkr_pkg::OP_CAL, ax, ahkr_pkg::THR_W'($urandom), tick(),
                          1'b0, NO_CHECK);
            end else if (k < 78) begin
                send_item(ahkr_pkg::OP_RESTORE, ax, ahkr_pkg::THR_W'($urandom), $urandom,
                          1'b0, NO_CHECK);
            end else if (k < 82) begin
                send_item(OP_UNUSED, ax, ahkr_pkg::THR_W'($urandom), $urandom,
                          1'b0, NO_CHECK);
            end else if (k < 83) begin
                drain_results();
            end else begin
                send_item(ahkr_pkg::OP_SAMPLE, ax, ahkr_pkg::THR_W'($urandom), tick(),
                          1'b0, NO_CHECK);
            end
        end
    endtask

    initial begin
        ahkr_pkg::cfg_t c;
        bit junk;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        row_typed  = 1'b0;
        row_result = NO_CHECK;
        dflt = '{lo_enter: ahkr_pkg::RST_LO_ENTER, lo_hold: ahkr_pkg::RST_LO_HOLD,
                 hi_hold: ahkr_pkg::RST_HI_HOLD, hi_enter: ahkr_pkg::RST_HI_ENTER,
                 delay: ahkr_pkg::RST_DELAY, interval: ahkr_pkg::RST_INTERVAL};
        load_defaults();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].axis, directed_rows[i].raw,
                      directed_rows[i].now, directed_rows[i].typed, directed_rows[i].result);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            // let any restore sweep finish
            repeat (12) @(posedge aclk);
            junk = 1'b0;
            case (ph)
                0: begin
                    c.lo_enter = ahkr_pkg::THR_W'($urandom_range(200, 1500));
                    c.lo_hold  = c.lo_enter + ahkr_pkg::THR_W'($urandom_range(0, 500));
                    c.hi_enter = ahkr_pkg::THR_W'($urandom_range(2500, 3900));
                    c.hi_hold  = c.hi_enter - ahkr_pkg::THR_W'($urandom_range(0, 500));
                    c.delay    = ahkr_pkg::MS_W'($urandom_range(0, 400));
                    c.interval = ahkr_pkg::MS_W'($urandom_range(0, 200));
                end
                1: c = '{lo_enter: '0, lo_hold: '0, hi_hold: ahkr_pkg::ADC_MAX,
                         hi_enter: ahkr_pkg::ADC_MAX, delay: '0, interval: '0};
                2: c = '{lo_enter: ahkr_pkg::ADC_MAX, lo_hold: ahkr_pkg::ADC_MAX,
                         hi_hold: '0, hi_enter: '0, delay: '1, interval: '1};
                3: begin
                    c = ahkr_pkg::cfg_t'({16'($urandom), $urandom, $urandom});
                    junk = 1'b1;
                end
                default: c = '{lo_enter: ahkr_pkg::RST_LO_ENTER,
                               lo_hold: ahkr_pkg::RST_LO_HOLD,
                               hi_hold: ahkr_pkg::RST_HI_HOLD,
                               hi_enter: ahkr_pkg::RST_HI_ENTER,
                               delay: ahkr_pkg::RST_DELAY,
                               interval: ahkr_pkg::RST_INTERVAL};
            endcase
            write_config(c, junk);
            calm = (ph == PHASES - 1);
            send_item(ahkr_pkg::OP_RESTORE, ahkr_pkg::AXIS_W'($urandom),
                      ahkr_pkg::THR_W'($urandom), $urandom, 1'b0, NO_CHECK);
            random_items(PHASE_ITEMS);
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (pending_events.size() != 0) begin
            $error("%0d expected results never arrived", pending_events.size());
            errs++;
        end
        $display("ran %0d items under %0d register settings", items_sent, settings_used);
        $display("%0d results checked, %0d key events, %0d errors",
                 results_seen, emits_seen, errs);
        if (errs == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
rtl/ahkr_pkg.sv
rtl/ahkr_cfg_regs.sv
rtl/ahkr_axis_mem.sv
rtl/ahkr_axis_update.sv
rtl/axis_hysteresis_key_repeat_top.sv
test/tb_top.sv
